/* src/lscl_pkg.sv */
package lscl_pkg;

  localparam int MAX_PIXELS_DEF = 64;

  localparam int BYTE_W = 8;
  localparam int PIX_W = 3 * BYTE_W;
  localparam int LIMIT_W = 16;
  localparam int MA_W = 8;
  localparam int SUM_W = 16;
  // limit * 256 and ma * sum both fit here
  localparam int NUM_W = LIMIT_W + BYTE_W;
  localparam int PROD_W = NUM_W + BYTE_W;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd500;
  localparam logic [MA_W-1:0] MA_RESET = 8'd20;

  typedef enum logic {
    REG_LIMIT = 1'b0,
    REG_MA    = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_CALC,
    ST_RD,
    ST_START,
    ST_WAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic over;
  } scl_ctrl_t;

endpackage

/* src/lscl_in_if.sv */
interface lscl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] green_in;
  logic [7:0] red_in;
  logic [7:0] blue_in;
  logic       frame_end;

  modport source (output valid, output green_in, output red_in, output blue_in,
                  output frame_end, input ready);
  modport sink (input valid, input green_in, input red_in, input blue_in,
                input frame_end, output ready);
endinterface

/* src/lscl_out_if.sv */
interface lscl_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] green_out;
  logic [7:0] red_out;
  logic [7:0] blue_out;
  logic       last_pixel;

  modport source (output valid, output green_out, output red_out, output blue_out,
                  output last_pixel, input ready);
  modport sink (input valid, input green_out, input red_out, input blue_out,
                input last_pixel, output ready);
endinterface

/* src/lscl_pixel_mem.sv */
module lscl_pixel_mem #(
  parameter int DEPTH = lscl_pkg::MAX_PIXELS_DEF,
  parameter int AW = 6
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [lscl_pkg::PIX_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [lscl_pkg::PIX_W-1:0] rdata
);
  import lscl_pkg::*;

  logic [PIX_W-1:0] mem_r [DEPTH];
  logic [PIX_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/lscl_scaler.sv */
// Scales the three bytes of one pixel by num/den (passes it through when over is clear):
// one 8x24 multiply per channel, then a restoring divide, two quotient bits per cycle.
module lscl_scaler (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lscl_pkg::scl_ctrl_t        ctrl,
  input  logic [lscl_pkg::NUM_W-1:0] num,
  input  logic [lscl_pkg::NUM_W-1:0] den,
  input  logic [lscl_pkg::PIX_W-1:0] pix,
  output logic [lscl_pkg::PIX_W-1:0] result,
  output logic                       done
);
  import lscl_pkg::*;

  logic [NUM_W-1:0]  rem_r [3];
  logic [NUM_W-1:0]  rem_nxt [3];
  logic [BYTE_W-1:0] low_r [3];
  logic [BYTE_W-1:0] low_nxt [3];
  logic [BYTE_W-1:0] q_r [3];
  logic [BYTE_W-1:0] q_nxt [3];
  logic [PROD_W-1:0] prod [3];
  logic [PIX_W-1:0]  pix_r;
  logic              over_r;
  logic              run_r;
  logic [1:0]        cnt_r;
  logic              done_r;

  // one restoring step: {quotient bit, new remainder}; remainder stays below den
  function automatic logic [NUM_W:0] div_step(input logic [NUM_W-1:0] rem, input logic b,
                                              input logic [NUM_W-1:0] d);
    logic [NUM_W:0] t;
    t = {rem, b};
    if (t >= {1'b0, d}) begin
      return {1'b1, NUM_W'(t - {1'b0, d})};
    end
    return {1'b0, t[NUM_W-1:0]};
  endfunction

  always_comb begin
    logic [NUM_W:0] s1;
    logic [NUM_W:0] s2;
    for (int c = 0; c < 3; c++) begin
      prod[c] = PROD_W'(pix[(2-c)*BYTE_W +: BYTE_W]) * PROD_W'(num);
      s1 = div_step(rem_r[c], low_r[c][BYTE_W-1], den);
      s2 = div_step(s1[NUM_W-1:0], low_r[c][BYTE_W-2], den);
      rem_nxt[c] = s2[NUM_W-1:0];
      low_nxt[c] = {low_r[c][BYTE_W-3:0], 2'b00};
      q_nxt[c] = {q_r[c][BYTE_W-3:0], s1[NUM_W], s2[NUM_W]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= 2'd0;
      done_r <= 1'b0;
    end else begin
      done_r <= run_r && (cnt_r == 2'd3);
      if (ctrl.start) begin
        run_r <= 1'b1;
        cnt_r <= 2'd0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  // dividend < den * 256 when over, so its upper part starts below den
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      pix_r <= pix;
      over_r <= ctrl.over;
      for (int c = 0; c < 3; c++) begin
        rem_r[c] <= prod[c][PROD_W-1:BYTE_W];
        low_r[c] <= prod[c][BYTE_W-1:0];
      end
    end else if (run_r) begin
      for (int c = 0; c < 3; c++) begin
        rem_r[c] <= rem_nxt[c];
        low_r[c] <= low_nxt[c];
        q_r[c] <= q_nxt[c];
      end
    end
  end

  assign result = over_r ? {q_r[0], q_r[1], q_r[2]} : pix_r;
  assign done = done_r;

endmodule

/* src/led_strip_current_limiter_top.sv */
// LED strip current limiter.
// in_chan takes one pixel per beat (green, red, blue, frame_end). Pixels are
// stored in an on-chip pixel memory while all channel bytes are summed; a
// pixel that arrives with the memory full is dropped. The beat with frame_end
// closes the frame: the estimated current sum * ma_per_channel / 256 is
// compared with limit_milliamps and, when over, each byte of each stored pixel
// is scaled by limit * 256 / (ma * sum), rounded down.
// Loading accepts one pixel per cycle. On frame_end the block stops taking
// input and drains the frame on out_chan, last_pixel set on the final beat.
// Each emitted pixel goes through a memory read, a multiply, a two-bit-per-cycle
// divider, a registered done flag, then the output beat; the next pixel is not
// read until the receiver takes the current beat. The first beat follows the
// frame_end beat through the ST_CALC, ST_RD, ST_START and ST_WAIT states.
// If out_chan stalls the output register holds its beat and the drain waits.
// Registers on the APB port: 0x0 limit_milliamps, 0x4 ma_per_channel.
// Synchronous reset empties the frame and loads limit 500 mA, 20 mA per
// channel; memory contents are not cleared.
module led_strip_current_limiter_top #(
  parameter int MAX_PIXELS = lscl_pkg::MAX_PIXELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  lscl_in_if.sink                         in_chan,
  lscl_out_if.source                      out_chan,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lscl_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [lscl_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [lscl_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import lscl_pkg::*;

  localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int CW = $clog2(MAX_PIXELS + 1);

  state_t            state_r;
  state_t            state_nxt;
  logic [CW-1:0]     count_r;
  logic [SUM_W-1:0]  sum_r;
  logic [AW-1:0]     idx_r;
  logic [LIMIT_W-1:0] limit_r;
  logic [MA_W-1:0]   ma_r;
  logic [NUM_W-1:0]  num_r;
  logic [NUM_W-1:0]  den_r;
  logic              over_r;
  logic              out_valid_r;
  logic [PIX_W-1:0]  out_pix_r;
  logic              out_last_r;

  logic              in_fire;
  logic              store_ok;
  logic              last_idx;
  logic              mem_we;
  logic              mem_re;
  logic [PIX_W-1:0]  mem_rdata;
  logic [PIX_W-1:0]  scl_result;
  logic              scl_done;
  scl_ctrl_t         scl_ctrl;

  assign in_fire = in_chan.valid && in_chan.ready;
  assign store_ok = count_r < CW'(MAX_PIXELS);
  assign last_idx = (CW'(idx_r) + CW'(1)) == count_r;

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MA) ? CFG_DATA_W'(ma_r) : CFG_DATA_W'(limit_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
      ma_r <= MA_RESET;
    end else if (psel && penable && pwrite) begin
      case (reg_idx_t'(paddr[2]))
        REG_LIMIT: limit_r <= pwdata[LIMIT_W-1:0];
        REG_MA:    ma_r <= pwdata[MA_W-1:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD:  if (in_fire && in_chan.frame_end) state_nxt = ST_CALC;
      ST_CALC:  state_nxt = ST_RD;
      ST_RD:    state_nxt = ST_START;
      ST_START: state_nxt = ST_WAIT;
      ST_WAIT:  if (scl_done) state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_chan.ready) begin
          state_nxt = out_last_r ? ST_LOAD : ST_RD;
        end
      end
      default:  state_nxt = ST_LOAD;
    endcase
  end

  // outputs
  always_comb begin
    in_chan.ready = 1'b0;
    mem_we = 1'b0;
    mem_re = 1'b0;
    scl_ctrl = '0;
    case (state_r)
      ST_LOAD: begin
        in_chan.ready = 1'b1;
        mem_we = in_fire && store_ok;
      end
      ST_RD:    mem_re = 1'b1;
      ST_START: begin
        scl_ctrl.start = 1'b1;
        scl_ctrl.over = over_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      count_r <= '0;
      sum_r <= '0;
      idx_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_LOAD: begin
          if (mem_we) begin
            count_r <= count_r + CW'(1);
            sum_r <= sum_r + SUM_W'(in_chan.green_in) + SUM_W'(in_chan.red_in)
                     + SUM_W'(in_chan.blue_in);
          end
          idx_r <= '0;
        end
        ST_WAIT: begin
          if (scl_done) begin
            out_valid_r <= 1'b1;
          end
        end
        ST_OUT: begin
          if (out_chan.ready) begin
            out_valid_r <= 1'b0;
            if (out_last_r) begin
              count_r <= '0;
              sum_r <= '0;
            end else begin
              idx_r <= idx_r + AW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == ST_CALC) begin
      num_r <= {limit_r, 8'd0};
      den_r <= NUM_W'(ma_r) * NUM_W'(sum_r);
    end
    if (state_r == ST_RD) begin
      over_r <= num_r < den_r;
    end
    if (state_r == ST_WAIT && scl_done) begin
      out_pix_r <= scl_result;
      out_last_r <= last_idx;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.green_out = out_pix_r[PIX_W-1 -: BYTE_W];
  assign out_chan.red_out = out_pix_r[BYTE_W +: BYTE_W];
  assign out_chan.blue_out = out_pix_r[BYTE_W-1:0];
  assign out_chan.last_pixel = out_last_r;

  lscl_pixel_mem #(
    .DEPTH (MAX_PIXELS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (count_r[AW-1:0]),
    .wdata ({in_chan.green_in, in_chan.red_in, in_chan.blue_in}),
    .re    (mem_re),
    .raddr (idx_r),
    .rdata (mem_rdata)
  );

  lscl_scaler u_scaler (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (scl_ctrl),
    .num    (num_r),
    .den    (den_r),
    .pix    (mem_rdata),
    .result (scl_result),
    .done   (scl_done)
  );

endmodule
